// ===== hw/rtl/dthd_pkg.sv =====
// ----------------------------------------------------------------------------
// dthd_pkg
// Types and constants shared by the DER tag-length header decoder modules.
// ----------------------------------------------------------------------------
package dthd_pkg;

   // header parse phase
   typedef enum logic [1:0] {
      PHASE_IDLE         = 2'd0,
      PHASE_LENGTH_OCTET = 2'd1,
      PHASE_LONG_LENGTH  = 2'd2
   } phase_type;

   // identifier octet of a bit string
   localparam logic [7:0] TAG_BIT_STRING = 8'h03;
   // long-form flag and count mask of the first length octet
   localparam logic [7:0] LONG_FORM_FLAG = 8'h80;
   localparam logic [6:0] LENGTH_COUNT_MASK = 7'h7F;
   // tag octet plus first length octet
   localparam logic [31:0] HEADER_MIN = 32'd2;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

   // one incoming request byte
   typedef struct packed {
      logic [7:0]  data_byte;
      logic        first_byte;
      logic [31:0] available_bytes;
   } item_type;

   // one decoded header
   typedef struct packed {
      logic [7:0]  tag_value;
      logic [31:0] content_length;
      logic [2:0]  content_offset;
      logic [31:0] total_length;
      logic        status;
   } result_type;

endpackage

// ===== hw/rtl/der_tlv_header_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// der_tlv_header_decoder_unit
// Parses ASN.1 DER tag-length headers from a byte stream, one byte a cycle unless stalled.
//
//   channel  direction  handshake          payload
//   req_     in         req_valid/stall    data_byte, first_byte, available_bytes
//   rsp_     out        rsp_valid/stall    tag, content length/offset, total, status
//
// One request byte is taken every cycle while req_stall is low; the result of
// the byte that completes (or breaks) a header passes through the input
// register, the single decode stage and the result register.
// Reset is synchronous and clears the parse phase and both stage valids.
// rsp_stall holds the result register; req_stall rises only when a byte is
// waiting in the input register and the result register cannot drain.
// ----------------------------------------------------------------------------
module der_tlv_header_decoder_unit #(
   parameter int MAX_LENGTH_BYTES = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_byte,
   input  logic [31:0] req_available_bytes,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_tag_value,
   output logic [31:0] rsp_content_length,
   output logic [2:0]  rsp_content_offset,
   output logic [31:0] rsp_total_length,
   output logic        rsp_status
);

   dthd_pkg::item_type   req_item;
   dthd_pkg::item_type   item;
   logic                 item_valid;
   logic                 advance;
   logic                 result_valid;
   dthd_pkg::result_type result;
   dthd_pkg::result_type rsp_result;

   assign req_item.data_byte       = req_data_byte;
   assign req_item.first_byte      = req_first_byte;
   assign req_item.available_bytes = req_available_bytes;

   dthd_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   dthd_decode #(
      .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
   ) u_decode (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (item_valid),
      .item         (item),
      .advance      (advance),
      .result_valid (result_valid),
      .result       (result)
   );

   dthd_output_stage u_output (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (item_valid),
      .result_valid (result_valid),
      .result       (result),
      .rsp_stall    (rsp_stall),
      .advance      (advance),
      .rsp_valid    (rsp_valid),
      .rsp_result   (rsp_result)
   );

   assign rsp_tag_value      = rsp_result.tag_value;
   assign rsp_content_length = rsp_result.content_length;
   assign rsp_content_offset = rsp_result.content_offset;
   assign rsp_total_length   = rsp_result.total_length;
   assign rsp_status         = rsp_result.status;

endmodule

// ===== hw/rtl/dthd_input_stage.sv =====
// ----------------------------------------------------------------------------
// dthd_input_stage
// Input register: holds one request until the decode stage takes it.
// ----------------------------------------------------------------------------
module dthd_input_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  dthd_pkg::item_type req_item,
   input  logic               advance,
   output logic               item_valid,
   output dthd_pkg::item_type item
);

   logic               valid_ff;
   logic               valid_in;
   dthd_pkg::item_type item_ff;
   logic               accept;

   // stall only while a held request cannot move on
   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   // control register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== hw/rtl/dthd_decode.sv =====
// ----------------------------------------------------------------------------
// dthd_decode
// Header parse state and per-byte decode: tag, short or long form length,
// bounds checks and result build.
// ----------------------------------------------------------------------------
module dthd_decode #(
   parameter int MAX_LENGTH_BYTES = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  dthd_pkg::item_type   item,
   input  logic                 advance,
   output logic                 result_valid,
   output dthd_pkg::result_type result
);

   localparam int LTR_W = $clog2(MAX_LENGTH_BYTES + 1);
   // header length plus the bit string skip, never below three bits
   localparam int HC_W  = $clog2(MAX_LENGTH_BYTES + 4);

   dthd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]          tag_ff, tag_in;
   logic [31:0]         bytes_left_ff, bytes_left_in;
   logic [LTR_W-1:0]    ltr_ff, ltr_in;
   logic [31:0]         acc_ff, acc_in;
   logic [HC_W-1:0]     hc_ff, hc_in;

   logic        step;
   logic [7:0]  b;
   logic        first;
   logic [31:0] avail;
   logic        short_avail;
   logic        long_form;
   logic [6:0]  count;
   logic        count_err;
   logic        last_len_byte;
   logic [31:0] acc_next;
   logic [HC_W-1:0] hc_plus;

   logic        finish;
   logic        early_err;
   logic [31:0] fin_len;
   logic [HC_W-1:0] fin_hc;
   logic        is_bit;
   logic        fin_err;
   logic [HC_W-1:0] fin_offset;

   assign step  = item_valid && advance;
   assign b     = item.data_byte;
   assign first = item.first_byte;
   assign avail = item.available_bytes;

   // field decode
   assign short_avail   = avail < dthd_pkg::HEADER_MIN;
   assign long_form     = (b & dthd_pkg::LONG_FORM_FLAG) != 8'd0;
   assign count         = b[6:0] & dthd_pkg::LENGTH_COUNT_MASK;
   assign count_err     = (32'(count) > bytes_left_ff) ||
                          (32'(count) > 32'(MAX_LENGTH_BYTES));
   assign last_len_byte = (ltr_ff == LTR_W'(0)) || (ltr_ff == LTR_W'(1));
   assign acc_next      = {acc_ff[23:0], b};
   assign hc_plus       = hc_ff + HC_W'(1);

   // where a header completes, and the length it completes with
   always_comb begin
      finish    = 1'b0;
      early_err = 1'b0;
      fin_len   = 32'd0;
      fin_hc    = hc_ff;
      if (first) begin
         early_err = short_avail;
      end else begin
         case (phase_ff)
            dthd_pkg::PHASE_LENGTH_OCTET: begin
               if (!long_form) begin
                  finish  = 1'b1;
                  fin_len = {24'd0, b};
               end else if (count_err) begin
                  early_err = 1'b1;
               end else if (count == 7'd0) begin
                  finish = 1'b1;
               end
            end
            dthd_pkg::PHASE_LONG_LENGTH: begin
               fin_hc = hc_plus;
               if (last_len_byte) begin
                  finish  = 1'b1;
                  fin_len = acc_next;
               end
            end
            default: begin
               finish = 1'b0;
            end
         endcase
      end
   end

   // completion checks
   assign is_bit     = tag_ff == dthd_pkg::TAG_BIT_STRING;
   assign fin_err    = (bytes_left_ff < fin_len) || (is_bit && (fin_len == 32'd0));
   assign fin_offset = fin_hc + HC_W'(is_bit);

   // result build
   always_comb begin
      result_valid = finish || early_err;
      result       = '0;
      if (early_err || fin_err) begin
         result.status = dthd_pkg::STATUS_ERROR;
      end else begin
         result.status         = dthd_pkg::STATUS_OK;
         result.tag_value      = tag_ff;
         result.content_length = is_bit ? (fin_len - 32'd1) : fin_len;
         result.content_offset = fin_offset[2:0];
         result.total_length   = 32'(fin_hc) + fin_len;
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         if (first) begin
            phase_in = short_avail ? dthd_pkg::PHASE_IDLE : dthd_pkg::PHASE_LENGTH_OCTET;
         end else begin
            case (phase_ff)
               dthd_pkg::PHASE_LENGTH_OCTET: begin
                  if (long_form && !count_err && (count != 7'd0)) begin
                     phase_in = dthd_pkg::PHASE_LONG_LENGTH;
                  end else begin
                     phase_in = dthd_pkg::PHASE_IDLE;
                  end
               end
               dthd_pkg::PHASE_LONG_LENGTH: begin
                  phase_in = last_len_byte ? dthd_pkg::PHASE_IDLE
                                           : dthd_pkg::PHASE_LONG_LENGTH;
               end
               default: begin
                  phase_in = dthd_pkg::PHASE_IDLE;
               end
            endcase
         end
      end
   end

   // header context updates
   always_comb begin
      tag_in        = tag_ff;
      bytes_left_in = bytes_left_ff;
      ltr_in        = ltr_ff;
      acc_in        = acc_ff;
      hc_in         = hc_ff;
      if (step) begin
         if (first) begin
            tag_in        = b;
            ltr_in        = '0;
            acc_in        = '0;
            hc_in         = HC_W'(dthd_pkg::HEADER_MIN);
            bytes_left_in = short_avail ? 32'd0 : (avail - dthd_pkg::HEADER_MIN);
         end else begin
            case (phase_ff)
               dthd_pkg::PHASE_LENGTH_OCTET: begin
                  if (long_form && !count_err && (count != 7'd0)) begin
                     bytes_left_in = bytes_left_ff - 32'(count);
                     ltr_in        = count[LTR_W-1:0];
                     acc_in        = '0;
                  end
               end
               dthd_pkg::PHASE_LONG_LENGTH: begin
                  acc_in = acc_next;
                  hc_in  = hc_plus;
                  if (ltr_ff != LTR_W'(0)) begin
                     ltr_in = ltr_ff - LTR_W'(1);
                  end
               end
               default: begin
                  ltr_in = ltr_ff;
               end
            endcase
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= dthd_pkg::PHASE_IDLE;
         tag_ff        <= '0;
         bytes_left_ff <= '0;
         ltr_ff        <= '0;
         acc_ff        <= '0;
         hc_ff         <= '0;
      end else begin
         phase_ff      <= phase_in;
         tag_ff        <= tag_in;
         bytes_left_ff <= bytes_left_in;
         ltr_ff        <= ltr_in;
         acc_ff        <= acc_in;
         hc_ff         <= hc_in;
      end
   end

endmodule

// ===== hw/rtl/dthd_output_stage.sv =====
// ----------------------------------------------------------------------------
// dthd_output_stage
// Result register: holds a decoded header until the consumer takes it.
// ----------------------------------------------------------------------------
module dthd_output_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  logic                 result_valid,
   input  dthd_pkg::result_type result,
   input  logic                 rsp_stall,
   output logic                 advance,
   output logic                 rsp_valid,
   output dthd_pkg::result_type rsp_result
);

   logic                 valid_ff;
   logic                 valid_in;
   dthd_pkg::result_type result_ff;

   // the decode stage moves when the result register is free or draining
   assign advance = !valid_ff || !rsp_stall;

   always_comb begin
      if (advance) begin
         valid_in = item_valid && result_valid;
      end else begin
         valid_in = valid_ff;
      end
   end

   // control register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      if (advance && item_valid && result_valid) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

// ===== hw/rtl/dthd_port_checker.sv =====
// ----------------------------------------------------------------------------
// dthd_port_checker
// Port-level checks on the header decoder result channel.
// ----------------------------------------------------------------------------
module dthd_port_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_tag_value,
   input logic [31:0] rsp_content_length,
   input logic [2:0]  rsp_content_offset,
   input logic [31:0] rsp_total_length,
   input logic        rsp_status
);

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_tag_value) &&
         $stable(rsp_content_length) && $stable(rsp_content_offset) &&
         $stable(rsp_total_length) && $stable(rsp_status))
      else $error("result changed while stalled");

   // nothing is presented right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // error results carry zero fields
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_tag_value == 8'd0 &&
         rsp_content_length == 32'd0 && rsp_content_offset == 3'd0 &&
         rsp_total_length == 32'd0)
      else $error("error result with nonzero fields");

   // the header always adds to the content
   a_total_covers: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_status |-> rsp_content_length < rsp_total_length)
      else $error("total length does not exceed content length");

   // request stall only holds back a presented request while output is stuck
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with free result register");

endmodule

bind der_tlv_header_decoder_unit dthd_port_checker u_dthd_port_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_tag_value      (rsp_tag_value),
   .rsp_content_length (rsp_content_length),
   .rsp_content_offset (rsp_content_offset),
   .rsp_total_length   (rsp_total_length),
   .rsp_status         (rsp_status)
);
